// ===== design/pso_pkg.sv =====
// Types, codes and fixed-point helpers for the pattern search optimizer.
// No dependencies; imported by pattern_search_optimizer.
package pso_pkg;

  localparam int NumVars = 2;
  localparam int CoordW  = 32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CoordW:0]          mag_t;
  typedef logic signed [CoordW+1:0] wide_t;
  typedef logic [15:0]              rho_t;

  // Search phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_INIT  = 2'd1;
  localparam logic [1:0] PH_PROBE = 2'd2;

  // Request and result codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_VALUE = 1'b1;
  localparam logic RES_PROBE = 1'b0;
  localparam logic RES_DONE  = 1'b1;

  // Register indexes.
  localparam logic [1:0] REG_SHRINK = 2'd0;
  localparam logic [1:0] REG_STOP   = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  // Saturate a wide signed value to the coordinate range.
  function automatic coord_t sat_c(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = wide_t'({1'b0, {(CoordW-1){1'b1}}});
    lo = -hi - wide_t'(1);
    if (v > hi) return coord_t'(hi);
    else if (v < lo) return coord_t'(lo);
    else return coord_t'(v);
  endfunction

  // Magnitude of a coordinate, one bit wider so the most negative value fits.
  function automatic mag_t mag_c(coord_t v);
    wide_t w;
    w = wide_t'(v);
    if (v < 0) w = -w;
    return mag_t'(w);
  endfunction

  // Sign-extend a coordinate to the wide type.
  function automatic wide_t wide_c(coord_t v);
    return wide_t'(v);
  endfunction

  // Multiply by rho (Q0.16), truncating toward zero and keeping the sign.
  function automatic coord_t scale_c(coord_t v, rho_t rho);
    logic [CoordW+16:0] p;
    wide_t m;
    p = {16'd0, mag_c(v)} * {{(CoordW+1){1'b0}}, rho};
    m = wide_t'({1'b0, p[CoordW+16:16]});
    if (v < 0) m = -m;
    return sat_c(m);
  endfunction

endpackage

// ===== design/pattern_search_optimizer.sv =====
// Two-variable Hooke-Jeeves pattern search controller.
// Depends on pso_pkg for types, codes and fixed-point helpers.
//
// Usage: a beat on the input channel either starts a new search (req_type 0,
// start point on start_x0/start_x1) or returns the objective value for the
// last point handed out (req_type 1). Each accepted beat yields at most one
// result beat: the next point to evaluate, or, with result_kind 1, the final
// base point. A value beat while no search runs gives no result.
// All the work for a beat is done in one combinational pass between the input
// handshake and the output register, so one beat per cycle can be taken unless
// stalled. The pass holds 33x16 multiplies by rho for the offsets and a 16x16
// multiply for the step. The input is stalled only while the output register
// holds a beat that the receiver is stalling; it resumes in the same cycle the
// beat is taken. Reset clears the search to idle and loads rho 0.5, epsilon 1
// and an iteration limit of 5000. Configuration is written through cfg_wr_en,
// cfg_index and cfg_data; the user must write only while no search beat is
// pending, which the block does not enforce.
module pattern_search_optimizer
  import pso_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_start_x0,
  input  logic [31:0] in_start_x1,
  input  logic [31:0] in_objective_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [31:0] out_point_x0,
  output logic [31:0] out_point_x1,
  output logic [31:0] out_best_value,
  output logic [15:0] out_iterations_done,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  // Configuration registers.
  rho_t        shrink_r;
  logic [30:0] stop_r;
  logic [15:0] limit_r;

  // Search state.
  logic [1:0]  phase_r, phase_nxt;
  logic        coord_r, coord_nxt;
  logic        tried_r, tried_nxt;
  logic        pattern_r, pattern_nxt;
  coord_t      base_r [NumVars];
  coord_t      base_nxt [NumVars];
  coord_t      origin_r [NumVars];
  coord_t      origin_nxt [NumVars];
  coord_t      probe_r [NumVars];
  coord_t      probe_nxt [NumVars];
  coord_t      offset_r [NumVars];
  coord_t      offset_nxt [NumVars];
  coord_t      best_r, best_nxt;
  coord_t      runmin_r, runmin_nxt;
  rho_t        step_r, step_nxt;
  logic [15:0] iter_r, iter_nxt;

  // Output register.
  logic        out_valid_r;
  logic        kind_r;
  coord_t      px0_r, px1_r, pbest_r;
  logic [15:0] piter_r;

  logic        in_accept;
  logic        res_valid;
  logic        res_kind;
  coord_t      res_x0, res_x1, res_best;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // One pass of the search for the accepted beat.
  always_comb begin
    coord_t  v;
    coord_t  x;
    coord_t  d;
    coord_t  newf;
    coord_t  prev;
    mag_t    m;
    logic    emitted;
    logic    do_top;
    logic    go_on;
    logic [CoordW+1:0] twice_d;
    logic [31:0] step_prod;

    phase_nxt   = phase_r;
    coord_nxt   = coord_r;
    tried_nxt   = tried_r;
    pattern_nxt = pattern_r;
    base_nxt    = base_r;
    origin_nxt  = origin_r;
    probe_nxt   = probe_r;
    offset_nxt  = offset_r;
    best_nxt    = best_r;
    runmin_nxt  = runmin_r;
    step_nxt    = step_r;
    iter_nxt    = iter_r;
    res_valid   = 1'b0;
    res_kind    = RES_PROBE;
    res_x0      = probe_r[0];
    res_x1      = probe_r[1];
    res_best    = runmin_r;
    v           = coord_t'(in_objective_value);
    emitted     = 1'b0;
    do_top      = 1'b0;
    go_on       = 1'b0;
    newf        = runmin_r;
    x           = '0;
    d           = '0;
    prev        = '0;
    m           = '0;
    twice_d     = '0;
    step_prod   = '0;

    if (in_accept) begin
      if (in_req_type == REQ_START) begin
        // Load the start point and the initial offsets.
        for (int k = 0; k < NumVars; k++) begin
          x = (k == 0) ? coord_t'(in_start_x0) : coord_t'(in_start_x1);
          base_nxt[k]   = x;
          origin_nxt[k] = x;
          probe_nxt[k]  = x;
          d = scale_c((x < 0) ? sat_c(-wide_c(x)) : x, shrink_r);
          offset_nxt[k] = (d == '0) ? coord_t'({16'd0, shrink_r}) : d;
        end
        step_nxt    = shrink_r;
        iter_nxt    = '0;
        best_nxt    = '0;
        runmin_nxt  = '0;
        coord_nxt   = 1'b0;
        tried_nxt   = 1'b0;
        pattern_nxt = 1'b0;
        phase_nxt   = PH_INIT;
        res_valid   = 1'b1;
        res_x0      = probe_nxt[0];
        res_x1      = probe_nxt[1];
        res_best    = '0;
      end else if (phase_r == PH_INIT) begin
        best_nxt   = v;
        runmin_nxt = v;
        do_top     = 1'b1;
      end else if (phase_r == PH_PROBE) begin
        // Exploratory move on the current coordinate.
        if (!tried_r) begin
          if (v < runmin_r) begin
            runmin_nxt = v;
          end else begin
            offset_nxt[coord_r] = sat_c(-wide_c(offset_r[coord_r]));
            probe_nxt[coord_r] = sat_c(wide_c(origin_r[coord_r]) +
                                       wide_c(offset_nxt[coord_r]));
            tried_nxt = 1'b1;
            emitted   = 1'b1;
          end
        end else if (v < runmin_r) begin
          runmin_nxt = v;
        end else begin
          probe_nxt[coord_r] = origin_r[coord_r];
        end

        if (emitted) begin
          res_valid = 1'b1;
          res_x0    = probe_nxt[0];
          res_x1    = probe_nxt[1];
          res_best  = runmin_nxt;
        end else if (coord_r == 1'b0) begin
          // Move on to the second coordinate.
          tried_nxt    = 1'b0;
          coord_nxt    = 1'b1;
          probe_nxt[1] = sat_c(wide_c(origin_r[1]) + wide_c(offset_r[1]));
          res_valid    = 1'b1;
          res_x0       = probe_nxt[0];
          res_x1       = probe_nxt[1];
          res_best     = runmin_nxt;
        end else begin
          // End of the exploratory sweep.
          newf       = runmin_nxt;
          origin_nxt = probe_nxt;
          if (!pattern_r) begin
            go_on = newf < best_r;
          end else if (newf < best_r) begin
            for (int k = 0; k < NumVars; k++) begin
              twice_d = {mag_c(sat_c(wide_c(origin_nxt[k]) - wide_c(base_r[k]))), 1'b0};
              if (wide_c(origin_nxt[k]) - wide_c(base_r[k]) == wide_t'(1) <<< CoordW ||
                  wide_c(base_r[k]) - wide_c(origin_nxt[k]) == wide_t'(1) <<< CoordW)
                twice_d = {1'b1, {(CoordW+1){1'b0}}};
              if (twice_d > {1'b0, mag_c(offset_r[k])}) go_on = 1'b1;
            end
          end

          if (go_on) begin
            // Pattern move along the successful direction.
            for (int k = 0; k < NumVars; k++) begin
              m    = mag_c(offset_r[k]);
              prev = base_r[k];
              offset_nxt[k] = (origin_nxt[k] <= base_r[k]) ?
                              sat_c(-wide_t'({1'b0, m})) : sat_c(wide_t'({1'b0, m}));
              base_nxt[k]   = origin_nxt[k];
              origin_nxt[k] = sat_c((wide_c(origin_nxt[k]) <<< 1) - wide_c(prev));
            end
            best_nxt     = newf;
            pattern_nxt  = 1'b1;
            runmin_nxt   = newf;
            probe_nxt    = origin_nxt;
            tried_nxt    = 1'b0;
            coord_nxt    = 1'b0;
            probe_nxt[0] = sat_c(wide_c(origin_nxt[0]) + wide_c(offset_nxt[0]));
            phase_nxt    = PH_PROBE;
            res_valid    = 1'b1;
            res_x0       = probe_nxt[0];
            res_x1       = probe_nxt[1];
            res_best     = runmin_nxt;
          end else begin
            // Shrink the step when nothing improved.
            if ({15'd0, step_r} >= stop_r && newf >= best_r) begin
              step_prod = {16'd0, step_r} * {16'd0, shrink_r};
              step_nxt  = step_prod[31:16];
              for (int k = 0; k < NumVars; k++)
                offset_nxt[k] = scale_c(offset_r[k], shrink_r);
            end
            do_top = 1'b1;
          end
        end
      end
    end

    // Top of the outer loop: next iteration or finish.
    if (do_top) begin
      if (iter_nxt < limit_r && {15'd0, step_nxt} > stop_r) begin
        iter_nxt     = iter_nxt + 16'd1;
        origin_nxt   = base_nxt;
        pattern_nxt  = 1'b0;
        runmin_nxt   = best_nxt;
        probe_nxt    = origin_nxt;
        tried_nxt    = 1'b0;
        coord_nxt    = 1'b0;
        probe_nxt[0] = sat_c(wide_c(origin_nxt[0]) + wide_c(offset_nxt[0]));
        phase_nxt    = PH_PROBE;
        res_valid    = 1'b1;
        res_kind     = RES_PROBE;
        res_x0       = probe_nxt[0];
        res_x1       = probe_nxt[1];
        res_best     = runmin_nxt;
      end else begin
        phase_nxt = PH_IDLE;
        res_valid = 1'b1;
        res_kind  = RES_DONE;
        res_x0    = base_nxt[0];
        res_x1    = base_nxt[1];
        res_best  = best_nxt;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shrink_r <= 16'd32768;
      stop_r   <= 31'd1;
      limit_r  <= 16'd5000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SHRINK: shrink_r <= cfg_data[15:0];
        REG_STOP:   stop_r   <= cfg_data;
        REG_LIMIT:  limit_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Search state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      coord_r   <= 1'b0;
      tried_r   <= 1'b0;
      pattern_r <= 1'b0;
      best_r    <= '0;
      runmin_r  <= '0;
      step_r    <= '0;
      iter_r    <= '0;
      for (int k = 0; k < NumVars; k++) begin
        base_r[k]   <= '0;
        origin_r[k] <= '0;
        probe_r[k]  <= '0;
        offset_r[k] <= '0;
      end
    end else begin
      phase_r   <= phase_nxt;
      coord_r   <= coord_nxt;
      tried_r   <= tried_nxt;
      pattern_r <= pattern_nxt;
      best_r    <= best_nxt;
      runmin_r  <= runmin_nxt;
      step_r    <= step_nxt;
      iter_r    <= iter_nxt;
      base_r    <= base_nxt;
      origin_r  <= origin_nxt;
      probe_r   <= probe_nxt;
      offset_r  <= offset_nxt;
    end
  end

  // Output register: loads when empty or when its beat is being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_valid_r || !out_stall) && res_valid) begin
      kind_r  <= res_kind;
      px0_r   <= res_x0;
      px1_r   <= res_x1;
      pbest_r <= res_best;
      piter_r <= iter_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_point_x0        = px0_r;
  assign out_point_x1        = px1_r;
  assign out_best_value      = pbest_r;
  assign out_iterations_done = piter_r;

endmodule
